@@ hdl/oso_pkg.sv @@
// Shared types, constants and tables of the obstacle sector occupancy unit.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package oso_pkg;

  // Sector count and derived stream widths
  localparam int NUM_SECTORS_DEF = 19;
  localparam int SECTOR_DEG      = 10;
  localparam int OUT_TDATA_W     = ((NUM_SECTORS_DEF + 7) / 8) * 8;

  // Field widths
  localparam int POS_W   = 32;
  localparam int TRIG_W  = 16;
  localparam int RANGE_W = 31;
  localparam int IN_TDATA_W = 2 * POS_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 3'd4;

  // Register reset values
  localparam logic signed [TRIG_W-1:0]  COS_RST   = 16'sd16384;
  localparam logic [RANGE_W-1:0]        RANGE_RST = 31'd65536;

  // Bearing unit
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int Z_W          = 24;
  localparam logic signed [Z_W-1:0] DEG90_Q16  = 24'sd5898240;
  localparam logic [Z_W-1:0]        DEG180_Q16 = 24'd11796480;
  localparam logic [7:0]            DEG180     = 8'd180;
  // deg / 10 as (deg * 205) >> 11, exact for deg below 1029
  localparam logic [7:0]            DIV10_MUL  = 8'd205;

  // atan(2^-i) in Q.16 degrees, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:  v = 24'sd2949120;
      4'd1:  v = 24'sd1740967;
      4'd2:  v = 24'sd919879;
      4'd3:  v = 24'sd466945;
      4'd4:  v = 24'sd234379;
      4'd5:  v = 24'sd117304;
      4'd6:  v = 24'sd58666;
      4'd7:  v = 24'sd29335;
      4'd8:  v = 24'sd14668;
      4'd9:  v = 24'sd7334;
      4'd10: v = 24'sd3667;
      4'd11: v = 24'sd1833;
      4'd12: v = 24'sd917;
      4'd13: v = 24'sd458;
      4'd14: v = 24'sd229;
      4'd15: v = 24'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                mul;
    logic                sum;
    logic                sqr;
    logic                cordic_init;
    logic                cordic_step;
    logic [STEP_W-1:0]   step;
    logic                mark;
    logic                emit;
  } oso_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_range;
    logic slot_free;
  } oso_sts_t;

endpackage

@@ hdl/oso_ctrl.sv @@
// Sequencing controller of the obstacle sector occupancy unit.
// Walks one point through transform, range test, CORDIC and marking, and hands the mask on at a frame end.
// Depends on oso_pkg.
module oso_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             point_valid,
  input  logic             frame_last,
  input  oso_pkg::oso_sts_t sts,
  output oso_pkg::oso_cmd_t cmd
);
  import oso_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_CORD = 3'd5;
  localparam logic [2:0] S_MARK = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_r, last_nxt;
  logic              in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Decode state into commands and next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          last_nxt = frame_last;
          if (point_valid) begin
            state_nxt = S_MUL;
          end else if (frame_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.in_range) begin
          cmd.cordic_init = 1'b1;
          step_nxt        = '0;
          state_nxt       = S_CORD;
        end else begin
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        step_nxt        = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // Hold until the output register can take the mask
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ hdl/oso_dpath.sv @@
// Datapath of the obstacle sector occupancy unit: configuration registers,
// frame transform, range test, CORDIC bearing, sector marks, output register.
// Depends on oso_pkg.
module oso_dpath #(
  parameter int NUM_SECTORS = oso_pkg::NUM_SECTORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [oso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [oso_pkg::POS_W-1:0]         cfg_data,
  input  logic [oso_pkg::POS_W-1:0]         point_x,
  input  logic [oso_pkg::POS_W-1:0]         point_y,
  input  oso_pkg::oso_cmd_t                 cmd,
  output oso_pkg::oso_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [NUM_SECTORS-1:0]            out_mask
);
  import oso_pkg::*;

  localparam int OFS_W  = POS_W + 1;            // 33 bit offsets
  localparam int PROD_W = OFS_W + TRIG_W;       // 49 bit products
  localparam int SUM_W  = PROD_W + 1;           // 50 bit sums
  localparam int FRM_W  = SUM_W - 14;           // 36 bit Q20.16 robot frame
  localparam int SQ_W   = 2 * RANGE_W;          // 62 bit squares
  localparam int XY_W   = RANGE_W + 16 + 4;     // 51 bit CORDIC vector
  localparam int WIN_W  = NUM_SECTORS + 4;

  // Configuration registers
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic [RANGE_W-1:0]       range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      cos_r   <= COS_RST;
      sin_r   <= '0;
      range_r <= RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X: pos_x_r <= cfg_data;
        REG_POS_Y: pos_y_r <= cfg_data;
        REG_COS:   cos_r   <= cfg_data[TRIG_W-1:0];
        REG_SIN:   sin_r   <= cfg_data[TRIG_W-1:0];
        REG_RANGE: range_r <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Offsets from the robot position
  logic signed [OFS_W-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= $signed({point_x[POS_W-1], point_x}) - $signed({pos_x_r[POS_W-1], pos_x_r});
      dy_r <= $signed({point_y[POS_W-1], point_y}) - $signed({pos_y_r[POS_W-1], pos_y_r});
    end
  end

  // Rotation products
  logic signed [PROD_W-1:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_xc_r <= dx_r * cos_r;
      p_ys_r <= dy_r * sin_r;
      p_yc_r <= dy_r * cos_r;
      p_xs_r <= dx_r * sin_r;
    end
  end

  // Sum, floor shift by 14, take magnitudes and signs
  logic signed [SUM_W-1:0] fwd_sum, lat_sum;
  logic signed [FRM_W-1:0] fwd, lat;
  logic [FRM_W-1:0]        af_r, al_r;
  logic                    fwd_neg_r, lat_neg_r, fwd_zero_r;

  assign fwd_sum = SUM_W'(p_xc_r) + SUM_W'(p_ys_r);
  assign lat_sum = SUM_W'(p_yc_r) - SUM_W'(p_xs_r);
  assign fwd     = fwd_sum[SUM_W-1:14];
  assign lat     = lat_sum[SUM_W-1:14];

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      af_r       <= fwd[FRM_W-1] ? FRM_W'(-fwd) : FRM_W'(fwd);
      al_r       <= lat[FRM_W-1] ? FRM_W'(-lat) : FRM_W'(lat);
      fwd_neg_r  <= fwd[FRM_W-1];
      lat_neg_r  <= lat[FRM_W-1];
      fwd_zero_r <= (fwd == '0);
    end
  end

  // Squares and per-axis bound
  logic [SQ_W-1:0] sqf_r, sql_r, r2_r;
  logic            near_r;

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      sqf_r  <= af_r[RANGE_W-1:0] * af_r[RANGE_W-1:0];
      sql_r  <= al_r[RANGE_W-1:0] * al_r[RANGE_W-1:0];
      r2_r   <= range_r * range_r;
      near_r <= (af_r < FRM_W'(range_r)) && (al_r < FRM_W'(range_r));
    end
  end

  logic [SQ_W:0] d2;
  assign d2           = {1'b0, sqf_r} + {1'b0, sql_r};
  assign sts.in_range = near_r && (d2 < {1'b0, r2_r});

  // CORDIC vectoring on (|lat|, |fwd|), one step per cycle
  logic signed [XY_W-1:0] x_r, y_r, sh_x, sh_y;
  logic signed [Z_W-1:0]  z_r;
  logic signed [Z_W-1:0]  atan_i;

  assign sh_x   = x_r >>> cmd.step;
  assign sh_y   = y_r >>> cmd.step;
  assign atan_i = atan_q16(cmd.step);

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      x_r <= $signed({4'b0, al_r[RANGE_W-1:0], 16'b0});
      y_r <= $signed({4'b0, af_r[RANGE_W-1:0], 16'b0});
      z_r <= '0;
    end else if (cmd.cordic_step) begin
      if (!y_r[XY_W-1]) begin
        x_r <= x_r + sh_y;
        y_r <= y_r - sh_x;
        z_r <= z_r + atan_i;
      end else begin
        x_r <= x_r - sh_y;
        y_r <= y_r + sh_x;
        z_r <= z_r - atan_i;
      end
    end
  end

  // Fold the angle into whole degrees and pick the sector window
  logic [Z_W-1:0]    z_clamp, theta;
  logic [7:0]        deg_f, deg;
  logic [15:0]       div_prod;
  logic [4:0]        sector;
  logic [WIN_W-1:0]  win;

  always_comb begin
    if (fwd_zero_r || z_r[Z_W-1]) begin
      z_clamp = '0;
    end else if (z_r > DEG90_Q16) begin
      z_clamp = DEG90_Q16;
    end else begin
      z_clamp = z_r;
    end
    theta    = lat_neg_r ? (DEG180_Q16 - z_clamp) : z_clamp;
    deg_f    = theta[Z_W-1:16];
    deg      = (fwd_neg_r && (deg_f != '0)) ? (DEG180 - deg_f) : deg_f;
    div_prod = deg * DIV10_MUL;
    sector   = div_prod[15:11];
    win      = WIN_W'(5'h1F) << sector;
  end

  // Sector marks and output register
  logic [NUM_SECTORS-1:0] marks_r;
  logic [NUM_SECTORS-1:0] out_mask_r;
  logic                   out_valid_r;

  assign sts.slot_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_mask      = out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        marks_r     <= '0;
        out_valid_r <= 1'b1;
      end else begin
        if (cmd.mark) begin
          marks_r <= marks_r | win[NUM_SECTORS+1:2];
        end
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_mask_r <= marks_r;
    end
  end

endmodule

@@ hdl/obstacle_sector_occupancy_unit.sv @@
// Obstacle sector occupancy unit, top level.
// Joins the controller and the datapath; depends on oso_pkg, oso_ctrl, oso_dpath.
//
// Takes one obstacle point per input transfer, moves it into the robot frame,
// and when it lies strictly inside the detection radius marks its 10 degree
// bearing sector and two neighbors on each side. An input transfer with tlast
// set sends the accumulated mask out and clears it. A point in range passes
// through the transform, square and compare steps, then the 16 CORDIC steps
// through one shared shift-add unit, then the marking step; a point out of
// range stops after the compare. A frame end then hands the mask to the
// output register, waiting while the previous mask has not yet been taken.
// One item is worked on at a time; in_tready is high only between items.
module obstacle_sector_occupancy_unit #(
  parameter int NUM_SECTORS = oso_pkg::NUM_SECTORS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: point_x [31:0], point_y [63:32]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [oso_pkg::IN_TDATA_W-1:0]        in_tdata,
  // in_tuser: point_valid [0]
  input  logic                                  in_tuser,
  // in_tlast: frame_last
  input  logic                                  in_tlast,
  // out_tdata: occupied_mask [NUM_SECTORS-1:0], zero above
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((NUM_SECTORS+7)/8)*8-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [oso_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [oso_pkg::POS_W-1:0]             cfg_data
);
  import oso_pkg::*;

  localparam int OUT_W = ((NUM_SECTORS + 7) / 8) * 8;

  oso_cmd_t               cmd;
  oso_sts_t               sts;
  logic [NUM_SECTORS-1:0] mask;

  assign cfg_ready = 1'b1;
  assign out_tdata = OUT_W'(mask);

  oso_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .point_valid (in_tuser),
    .frame_last  (in_tlast),
    .sts         (sts),
    .cmd         (cmd)
  );

  oso_dpath #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point_x   (in_tdata[POS_W-1:0]),
    .point_y   (in_tdata[2*POS_W-1:POS_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mask  (mask)
  );

endmodule

@@ hdl/oso_checker.sv @@
// Port-level checks of the obstacle sector occupancy unit, bound to the top.
// Depends on oso_pkg and obstacle_sector_occupancy_unit.
module oso_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [oso_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);
  import oso_pkg::*;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // A stalled mask holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output mask changed while stalled");

  // One item at a time: an item with a point or a frame end blocks the next transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser || in_tlast) |=> !in_tready)
    else $error("input accepted while previous item in flight");

  // A bare frame marker with an empty output slot passes through the emit state and then sets out_tvalid
  a_marker_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast && !in_tuser && !out_tvalid |-> ##2 out_tvalid)
    else $error("frame end marker did not emit a mask");

  // Padding above the mask stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:NUM_SECTORS_DEF] == '0))
    else $error("nonzero padding in output transfer");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind obstacle_sector_occupancy_unit oso_checker u_oso_checker (.*);
